FILE: rtl/ims_pkg.sv
// Shared constants, opcodes and helper functions for the Ising sweep engine.
`timescale 1ns / 1ps

package ims_pkg;

    // Lattice geometry
    localparam int SIDE   = 64;
    localparam int SITES  = SIDE * SIDE;
    localparam int XW     = $clog2(SIDE);
    localparam int AW     = $clog2(SITES);

    // Field widths
    localparam int OP_W   = 2;
    localparam int SITE_W = 12;
    localparam int SUM_W  = 14;
    localparam int VAL_W  = 30;
    localparam int CIDX_W = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_SWEEP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_SEED = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_THR4 = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_THR8 = 2'd2;

    // Subtractive generator
    localparam int PTR_W       = 6;
    localparam int GEN_LEN     = 55;
    localparam int GEN_DEPTH   = GEN_LEN + 1;
    localparam int GEN_STRIDE  = 21;
    localparam int GEN_LAG     = 31;
    localparam int GEN_SPLIT   = GEN_LEN - GEN_LAG;
    localparam logic [VAL_W-1:0] GEN_MOD    = 30'd1000000000;
    localparam logic [VAL_W-1:0] GEN_BASE   = 30'd161803398;
    localparam logic [VAL_W-1:0] SEED_RESET = 30'd137456;

    // a - b modulo the generator modulus, both below the modulus
    function automatic logic [VAL_W-1:0] gen_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[VAL_W])
        begin
            d = d + {1'b0, GEN_MOD};
        end
        return d[VAL_W-1:0];
    endfunction

    // table pointer step, 55 wraps to 1
    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(GEN_LEN)) ? PTR_W'(1) : p + PTR_W'(1);
    endfunction

endpackage

FILE: rtl/ims_if.sv
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps

interface ims_in_if;
    logic                      valid;
    logic                      ready;
    logic [ims_pkg::OP_W-1:0]  opcode;
    logic [ims_pkg::SITE_W-1:0] site_index;

    modport source (output valid, output opcode, output site_index, input ready);
    modport sink   (input valid, input opcode, input site_index, output ready);
endinterface

interface ims_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [ims_pkg::SUM_W-1:0] magnet_sum;
    logic                            spin_value;

    modport source (output valid, output magnet_sum, output spin_value, input ready);
    modport sink   (input valid, input magnet_sum, input spin_value, output ready);
endinterface

FILE: rtl/ising_metropolis_sweep_engine.sv
// Top level of the Ising Metropolis sweep engine.
`timescale 1ns / 1ps

// Periodic SIDE x SIDE lattice of one-bit spins in a single-port memory and
// a 55-word lagged subtractive generator in a small two-read memory. One
// input beat gives exactly one result beat. Opcode init fills every spin
// with +1 (one write a cycle), seeds the generator (55 writes) and mixes
// it (4 x 55 entries, each a read state then a write state). Opcode sweep
// visits sites in order y*SIDE+x; each site reads itself and its four
// neighbors through the one lattice port, then, when the energy change is
// positive, draws a word, and writes back. After reset the engine runs the
// init sequence with the reset seed and takes no beat until it finishes;
// it returns no result for that pass. Registers: 0 seed, 1 and 2 the
// acceptance thresholds for energy change 4 and 8. A result waiting in the
// output register does not block the next input beat.
module ising_metropolis_sweep_engine
(
    input  logic                       clk,
    input  logic                       rst_n,
    ims_in_if.sink                     in_ch,
    ims_out_if.source                  out_ch,
    input  logic                       cfg_we,
    input  logic [ims_pkg::CIDX_W-1:0] cfg_index,
    input  logic [ims_pkg::VAL_W-1:0]  cfg_data
);
    import ims_pkg::*;

    localparam logic [4:0] ST_FILL   = 5'd0;
    localparam logic [4:0] ST_SEED0  = 5'd1;
    localparam logic [4:0] ST_SEED1  = 5'd2;
    localparam logic [4:0] ST_MIX_RD = 5'd3;
    localparam logic [4:0] ST_MIX_WR = 5'd4;
    localparam logic [4:0] ST_IDLE   = 5'd5;
    localparam logic [4:0] ST_RESULT = 5'd6;
    localparam logic [4:0] ST_SW_C   = 5'd7;
    localparam logic [4:0] ST_SW_R   = 5'd8;
    localparam logic [4:0] ST_SW_L   = 5'd9;
    localparam logic [4:0] ST_SW_D   = 5'd10;
    localparam logic [4:0] ST_SW_U   = 5'd11;
    localparam logic [4:0] ST_SW_E   = 5'd12;
    localparam logic [4:0] ST_DR_RD  = 5'd13;
    localparam logic [4:0] ST_DR_WR  = 5'd14;
    localparam logic [4:0] ST_SW_W   = 5'd15;

    // configuration
    logic [VAL_W-1:0] seed_reg, thr4_reg, thr8_reg;

    // control
    logic [4:0]        state_reg, state_next;
    logic              boot_reg, boot_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [XW-1:0]     x_reg, x_next, y_reg, y_next;
    logic [PTR_W-1:0]  idx_reg, idx_next, pos_reg, pos_next;
    logic [1:0]        round_reg, round_next;
    logic [PTR_W-1:0]  draw_reg, draw_next, lag_reg, lag_next;
    logic              use_rd_reg, use_rd_next;
    logic              out_valid_reg, out_valid_next;

    // datapath
    logic [VAL_W-1:0]        mj_reg, mj_next, mk_reg, mk_next;
    logic                    s_reg, s_next, flip_reg, flip_next, big4_reg, big4_next;
    logic [2:0]              nplus_reg, nplus_next;
    logic [SUM_W-1:0]        acc_reg, acc_next, mag_reg, mag_next;
    logic [SUM_W-1:0]        out_mag_reg, out_mag_next;
    logic                    out_spin_reg, out_spin_next;

    // lattice memory, one port
    logic              spin_mem [SITES];
    logic [AW-1:0]     sp_addr;
    logic              sp_re, sp_we, sp_wd, sp_q;

    // generator memory, one write and two reads
    logic [VAL_W-1:0]  gen_mem [GEN_DEPTH];
    logic [PTR_W-1:0]  g_waddr, ga_addr, gb_addr;
    logic              g_we, g_re;
    logic [VAL_W-1:0]  g_wd, ga_q, gb_q;

    // helpers
    logic [XW-1:0]     xr, xl, yd, yu;
    logic [VAL_W-1:0]  seed_src, mj0, word;
    logic [PTR_W:0]    pos_sum;
    logic [2:0]        tot, mval;
    logic              in_fire, out_free, last_site, ns;

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign in_fire           = in_ch.valid && in_ch.ready;
    assign out_free          = !out_valid_reg || out_ch.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.magnet_sum = out_mag_reg;
    assign out_ch.spin_value = out_spin_reg;

    // neighbor coordinates on the torus
    assign xr = (x_reg == XW'(SIDE - 1)) ? '0 : x_reg + XW'(1);
    assign xl = (x_reg == '0) ? XW'(SIDE - 1) : x_reg - XW'(1);
    assign yd = (y_reg == XW'(SIDE - 1)) ? '0 : y_reg + XW'(1);
    assign yu = (y_reg == '0) ? XW'(SIDE - 1) : y_reg - XW'(1);
    assign last_site = (x_reg == XW'(SIDE - 1)) && (y_reg == XW'(SIDE - 1));

    // boot pass always uses the reset seed
    assign seed_src = boot_reg ? SEED_RESET : seed_reg;
    assign mj0      = (seed_src > GEN_BASE) ? seed_src - GEN_BASE : GEN_BASE - seed_src;
    assign pos_sum  = {1'b0, pos_reg} + (PTR_W + 1)'(GEN_STRIDE);

    // count of +1 neighbors, then alignment count m: flip energy is 4*(m-2)
    assign tot  = nplus_reg + {2'b00, sp_q};
    assign mval = s_reg ? tot : 3'd4 - tot;
    assign word = gen_sub(ga_q, gb_q);
    assign ns   = s_reg ^ flip_reg;

    function automatic logic [AW-1:0] site_addr(input logic [XW-1:0] x,
                                                input logic [XW-1:0] y);
        return AW'(y) * AW'(SIDE) + AW'(x);
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        round_next     = round_reg;
        draw_next      = draw_reg;
        lag_next       = lag_reg;
        use_rd_next    = use_rd_reg;
        mj_next        = mj_reg;
        mk_next        = mk_reg;
        s_next         = s_reg;
        flip_next      = flip_reg;
        big4_next      = big4_reg;
        nplus_next     = nplus_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_mag_next   = out_mag_reg;
        out_spin_next  = out_spin_reg;

        sp_addr = site_addr(x_reg, y_reg);
        sp_re   = 1'b0;
        sp_we   = 1'b0;
        sp_wd   = 1'b1;
        g_we    = 1'b0;
        g_re    = 1'b0;
        g_waddr = idx_reg;
        g_wd    = word;
        ga_addr = idx_reg;
        gb_addr = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    use_rd_next = 1'b0;
                    unique case (in_ch.opcode)
                        OP_INIT:
                        begin
                            cnt_next   = '0;
                            mag_next   = SUM_W'(SITES);
                            state_next = ST_FILL;
                        end
                        OP_SWEEP:
                        begin
                            x_next     = '0;
                            y_next     = '0;
                            acc_next   = '0;
                            state_next = ST_SW_C;
                        end
                        OP_READ:
                        begin
                            if (32'(in_ch.site_index) < SITES)
                            begin
                                sp_addr     = AW'(in_ch.site_index);
                                sp_re       = 1'b1;
                                use_rd_next = 1'b1;
                            end
                            state_next = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                sp_addr = cnt_reg;
                sp_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(SITES - 1))
                begin
                    state_next = ST_SEED0;
                end
            end
            ST_SEED0:
            begin
                g_we       = 1'b1;
                g_waddr    = PTR_W'(GEN_LEN);
                g_wd       = mj0;
                mj_next    = mj0;
                mk_next    = VAL_W'(1);
                pos_next   = PTR_W'(GEN_STRIDE);
                idx_next   = PTR_W'(1);
                state_next = ST_SEED1;
            end
            ST_SEED1:
            begin
                g_we    = 1'b1;
                g_waddr = pos_reg;
                g_wd    = mk_reg;
                mk_next = gen_sub(mj_reg, mk_reg);
                mj_next = mk_reg;
                pos_next = (pos_sum >= (PTR_W + 1)'(GEN_LEN))
                         ? PTR_W'(pos_sum - (PTR_W + 1)'(GEN_LEN)) : pos_sum[PTR_W-1:0];
                idx_next = idx_reg + PTR_W'(1);
                if (idx_reg == PTR_W'(GEN_LEN - 1))
                begin
                    idx_next   = PTR_W'(1);
                    round_next = '0;
                    state_next = ST_MIX_RD;
                end
            end
            ST_MIX_RD:
            begin
                g_re    = 1'b1;
                ga_addr = idx_reg;
                gb_addr = (idx_reg <= PTR_W'(GEN_SPLIT)) ? idx_reg + PTR_W'(GEN_LAG)
                                                        : idx_reg - PTR_W'(GEN_SPLIT);
                state_next = ST_MIX_WR;
            end
            ST_MIX_WR:
            begin
                g_we       = 1'b1;
                g_waddr    = idx_reg;
                g_wd       = word;
                idx_next   = idx_reg + PTR_W'(1);
                state_next = ST_MIX_RD;
                if (idx_reg == PTR_W'(GEN_LEN))
                begin
                    idx_next   = PTR_W'(1);
                    round_next = round_reg + 2'd1;
                    if (round_reg == 2'd3)
                    begin
                        draw_next   = '0;
                        lag_next    = PTR_W'(GEN_LAG);
                        boot_next   = 1'b0;
                        use_rd_next = 1'b0;
                        state_next  = boot_reg ? ST_IDLE : ST_RESULT;
                    end
                end
            end
            ST_SW_C:
            begin
                sp_re      = 1'b1;
                state_next = ST_SW_R;
            end
            ST_SW_R:
            begin
                sp_re      = 1'b1;
                sp_addr    = site_addr(xr, y_reg);
                s_next     = sp_q;
                state_next = ST_SW_L;
            end
            ST_SW_L:
            begin
                sp_re      = 1'b1;
                sp_addr    = site_addr(xl, y_reg);
                nplus_next = {2'b00, sp_q};
                state_next = ST_SW_D;
            end
            ST_SW_D:
            begin
                sp_re      = 1'b1;
                sp_addr    = site_addr(x_reg, yd);
                nplus_next = nplus_reg + {2'b00, sp_q};
                state_next = ST_SW_U;
            end
            ST_SW_U:
            begin
                sp_re      = 1'b1;
                sp_addr    = site_addr(x_reg, yu);
                nplus_next = nplus_reg + {2'b00, sp_q};
                state_next = ST_SW_E;
            end
            ST_SW_E:
            begin
                // energy change not positive: flip without a draw
                big4_next = (mval == 3'd4);
                if (mval <= 3'd2)
                begin
                    flip_next  = 1'b1;
                    state_next = ST_SW_W;
                end
                else
                begin
                    state_next = ST_DR_RD;
                end
            end
            ST_DR_RD:
            begin
                draw_next  = ptr_step(draw_reg);
                lag_next   = ptr_step(lag_reg);
                g_re       = 1'b1;
                ga_addr    = ptr_step(draw_reg);
                gb_addr    = ptr_step(lag_reg);
                state_next = ST_DR_WR;
            end
            ST_DR_WR:
            begin
                g_we       = 1'b1;
                g_waddr    = draw_reg;
                g_wd       = word;
                flip_next  = word < (big4_reg ? thr8_reg : thr4_reg);
                state_next = ST_SW_W;
            end
            ST_SW_W:
            begin
                sp_we    = 1'b1;
                sp_wd    = ns;
                acc_next = ns ? acc_reg + SUM_W'(1) : acc_reg - SUM_W'(1);
                x_next   = xr;
                if (x_reg == XW'(SIDE - 1))
                begin
                    y_next = yd;
                end
                state_next = ST_SW_C;
                if (last_site)
                begin
                    mag_next    = acc_next;
                    use_rd_next = 1'b0;
                    state_next  = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mag_next   = mag_reg;
                    out_spin_next  = use_rd_reg ? sp_q : 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg != ST_SW_E && state_reg != ST_DR_WR && state_reg != ST_SW_W)
        begin
            flip_next = 1'b0;
        end
    end

    // lattice memory
    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            spin_mem[sp_addr] <= sp_wd;
        end
        if (sp_re)
        begin
            sp_q <= spin_mem[sp_addr];
        end
    end

    // generator memory
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gen_mem[g_waddr] <= g_wd;
        end
        if (g_re)
        begin
            ga_q <= gen_mem[ga_addr];
            gb_q <= gen_mem[gb_addr];
        end
    end

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
            thr4_reg <= '0;
            thr8_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEED: seed_reg <= cfg_data;
                CFG_THR4: thr4_reg <= cfg_data;
                CFG_THR8: thr8_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            boot_reg      <= 1'b1;
            cnt_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            round_reg     <= '0;
            draw_reg      <= '0;
            lag_reg       <= PTR_W'(GEN_LAG);
            use_rd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            mag_reg       <= SUM_W'(SITES);
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            cnt_reg       <= cnt_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            draw_reg      <= draw_next;
            lag_reg       <= lag_next;
            use_rd_reg    <= use_rd_next;
            out_valid_reg <= out_valid_next;
            mag_reg       <= mag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mj_reg       <= mj_next;
        mk_reg       <= mk_next;
        s_reg        <= s_next;
        flip_reg     <= flip_next;
        big4_reg     <= big4_next;
        nplus_reg    <= nplus_next;
        acc_reg      <= acc_next;
        out_mag_reg  <= out_mag_next;
        out_spin_reg <= out_spin_next;
    end

endmodule

FILE: rtl/ims_check.sv
// Port-level checks for the Ising sweep engine and their bind.
`timescale 1ns / 1ps

module ims_check
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ims_pkg::SUM_W-1:0]  magnet_sum,
    input logic                       spin_value
);
    // a result beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(magnet_sum) && $stable(spin_value))
        else $error("result payload changed while stalled");

    // one item at a time: an accepted beat makes the engine busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again before the result was formed");

    // a result never appears in the cycle right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared without any work cycle");
endmodule

bind ising_metropolis_sweep_engine ims_check u_ims_check
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .magnet_sum (out_ch.magnet_sum),
    .spin_value (out_ch.spin_value)
);

FILE: tb/ising_metropolis_sweep_engine_tb.sv
// Testbench for the Ising Metropolis sweep engine: predicted spin sums and spin reads.
`timescale 1ns / 1ps

module ising_metropolis_sweep_engine_tb;
    import ims_pkg::*;

    localparam longint MOD_L      = 1000000000;
    localparam longint BASE_L     = 161803398;
    localparam int     CYCLE_CAP  = 3000000;
    localparam int     HOLD_LEN   = 400;
    localparam int     DRAIN_WAIT = 40;

    typedef struct packed
    {
        logic signed [SUM_W-1:0] magnet_sum;
        logic                    spin_value;
    } ising_result_t;

    // Tracks the lattice, the generator and the registers, and holds the
    // results still owed by the engine.
    class ising_scoreboard;
        bit            spins [SITES];
        longint        gen_words [GEN_DEPTH];
        int            draw_ptr;
        int            lag_ptr;
        int            spin_total;
        logic [VAL_W-1:0] seed_reg;
        logic [VAL_W-1:0] thr4_reg;
        logic [VAL_W-1:0] thr8_reg;
        ising_result_t owed [$];
        int            errors;

        function new();
            seed_reg   = SEED_RESET;
            thr4_reg   = '0;
            thr8_reg   = '0;
            errors     = 0;
            foreach (gen_words[i])
                gen_words[i] = 0;
            seed_generator();
            fill_lattice();
        endfunction

        function void fill_lattice();
            foreach (spins[i])
                spins[i] = 1'b1;
            spin_total = SITES;
        endfunction

        function void seed_generator();
            longint mj;
            longint mk;
            int     pos;
            mj = BASE_L - longint'(seed_reg);
            if (mj < 0)
                mj = -mj;
            mj = mj % MOD_L;
            mk = 1;
            gen_words[GEN_LEN] = mj;
            for (int i = 1; i < GEN_LEN; i++)
            begin
                pos = (GEN_STRIDE * i) % GEN_LEN;
                gen_words[pos] = mk;
                mk = mj - mk;
                if (mk < 0)
                    mk += MOD_L;
                mj = gen_words[pos];
            end
            for (int k = 0; k < 4; k++)
                for (int i = 1; i <= GEN_LEN; i++)
                begin
                    gen_words[i] -= gen_words[1 + (i + 30) % GEN_LEN];
                    if (gen_words[i] < 0)
                        gen_words[i] += MOD_L;
                end
            draw_ptr = 0;
            lag_ptr  = GEN_LAG;
        endfunction

        function longint next_word();
            longint w;
            draw_ptr = (draw_ptr >= GEN_LEN) ? 1 : draw_ptr + 1;
            lag_ptr  = (lag_ptr >= GEN_LEN) ? 1 : lag_ptr + 1;
            w = gen_words[draw_ptr] - gen_words[lag_ptr];
            if (w < 0)
                w += MOD_L;
            gen_words[draw_ptr] = w;
            return w;
        endfunction

        function int spin_pm(int x, int y);
            return spins[(y % SIDE) * SIDE + (x % SIDE)] ? 1 : -1;
        endfunction

        function void run_sweep();
            int  s;
            int  h;
            int  de;
            int  total;
            bit  flip;
            total = 0;
            for (int y = 0; y < SIDE; y++)
                for (int x = 0; x < SIDE; x++)
                begin
                    s  = spins[y * SIDE + x] ? 1 : -1;
                    h  = spin_pm(x + 1, y) + spin_pm(x + SIDE - 1, y)
                       + spin_pm(x, y + 1) + spin_pm(x, y + SIDE - 1);
                    de = 2 * s * h;
                    if (de <= 0)
                        flip = 1'b1;
                    else
                        flip = next_word() < longint'((de == 4) ? thr4_reg : thr8_reg);
                    if (flip)
                    begin
                        spins[y * SIDE + x] ^= 1'b1;
                        s = -s;
                    end
                    total += s;
                end
            spin_total = total;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [VAL_W-1:0] val);
            case (idx)
                CFG_SEED: seed_reg = val;
                CFG_THR4: thr4_reg = val;
                CFG_THR8: thr8_reg = val;
                default: ;
            endcase
        endfunction

        // accepted input beat: advance the state, queue the expected result
        function void note_input(logic [OP_W-1:0] op, logic [SITE_W-1:0] site);
            ising_result_t r;
            r.spin_value = 1'b0;
            case (op)
                OP_INIT:
                begin
                    fill_lattice();
                    seed_generator();
                end
                OP_SWEEP: run_sweep();
                OP_READ:
                    if (int'(site) < SITES)
                        r.spin_value = spins[site];
                default: ;
            endcase
            r.magnet_sum = SUM_W'(spin_total);
            owed.push_back(r);
        endfunction

        function void check_result(logic signed [SUM_W-1:0] sum, logic spin);
            ising_result_t e;
            if (owed.size() == 0)
            begin
                $display("%0t: result beat with none expected: sum %0d spin %0d",
                         $time, sum, spin);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (sum !== e.magnet_sum)
            begin
                $display("%0t: magnet_sum expected %0d actual %0d",
                         $time, e.magnet_sum, sum);
                errors++;
            end
            if (spin !== e.spin_value)
            begin
                $display("%0t: spin_value expected %0d actual %0d",
                         $time, e.spin_value, spin);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]  cfg_data;

    ims_in_if  in_ch ();
    ims_out_if out_ch ();

    ising_metropolis_sweep_engine DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ising_scoreboard lattice_sb = new();

    bit quiet_sender;   // no input gaps while set
    bit quiet_receiver; // no output stalls while set
    int hold_asks;      // bumped to ask the receiver for one long hold-off
    int sweeps_left;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Watchdog: generous cap over the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Result side: check each beat, then choose ready for the next edge.
    // Values read right after the edge are the pre-edge ones.
    initial
    begin : result_side
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left   = 0;
        hold_left    = 0;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                lattice_sb.check_result(out_ch.magnet_sum, out_ch.spin_value);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left   = pick_gap(quiet_receiver);
                out_ch.ready <= (stall_left == 0);
            end
        end
    end

    // One input beat; entered and left at a rising edge.
    task automatic send_beat(logic [OP_W-1:0] op, logic [SITE_W-1:0] site);
        int gap;
        gap = pick_gap(quiet_sender);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.site_index <= site;
        do
            @(posedge clk);
        while (!in_ch.ready);
        lattice_sb.note_input(op, site);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (lattice_sb.owed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all three registers back to back; the engine must be idle.
    task automatic load_regs(logic [VAL_W-1:0] seed, logic [VAL_W-1:0] t4,
                             logic [VAL_W-1:0] t8);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEED;
        cfg_data  <= seed;
        @(posedge clk);
        lattice_sb.write_reg(CFG_SEED, seed);
        cfg_index <= CFG_THR4;
        cfg_data  <= t4;
        @(posedge clk);
        lattice_sb.write_reg(CFG_THR4, t4);
        cfg_index <= CFG_THR8;
        cfg_data  <= t8;
        @(posedge clk);
        lattice_sb.write_reg(CFG_THR8, t8);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random beats: mostly reads, with init/sweep sequences spread through.
    // Sweeps are rationed since each one visits every site of the lattice.
    task automatic random_beats(int count);
        int r;
        logic [OP_W-1:0] op;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 10 && sweeps_left > 0)
            begin
                op = OP_SWEEP;
                sweeps_left--;
            end
            else if (r < 22)
                op = OP_INIT;
            else if (r < 30)
                op = OP_NONE;
            else
                op = OP_READ;
            send_beat(op, SITE_W'($urandom));
        end
    endtask

    function automatic logic [VAL_W-1:0] rand_thr();
        return VAL_W'($urandom_range(1000000000));
    endfunction

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_SEED;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_NONE;
        in_ch.site_index = '0;
        quiet_sender     = 1'b0;
        quiet_receiver   = 1'b0;
        hold_asks        = 0;
        sweeps_left      = 10;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First beat also waits out the init pass after reset.
        send_beat(OP_READ, 12'd0);

        // Zero thresholds: positive energy changes never flip.
        load_regs(30'd0, 30'd0, 30'd0);
        send_beat(OP_READ, 12'd4095);
        send_beat(OP_NONE, 12'hFFF);
        send_beat(OP_SWEEP, 12'h000);
        send_beat(OP_READ, 12'h555);
        send_beat(OP_INIT, 12'hAAA);
        send_beat(OP_READ, 12'hAAA);

        // Thresholds at the modulus: every site flips; largest seed.
        load_regs(30'd999999999, 30'd1000000000, 30'd1000000000);
        send_beat(OP_INIT, 12'd0);
        send_beat(OP_SWEEP, 12'd0);
        send_beat(OP_READ, 12'd0);
        send_beat(OP_SWEEP, 12'd4095);
        send_beat(OP_NONE, 12'd0);
        send_beat(OP_READ, 12'd4095);

        // Mid thresholds, seed equal to the generator base (mj of zero).
        load_regs(30'd161803398, 30'd500000000, 30'd100000000);
        send_beat(OP_INIT, 12'd1);
        send_beat(OP_SWEEP, 12'd2);
        send_beat(OP_READ, 12'd64);
        send_beat(OP_READ, 12'd63);
        send_beat(OP_INIT, 12'd0);

        // Random phases, the first with no idling on either side.
        quiet_sender   = 1'b1;
        quiet_receiver = 1'b1;
        load_regs(VAL_W'($urandom_range(999999999)), rand_thr(), rand_thr());
        random_beats(20);
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;

        load_regs(30'd0, 30'd1000000000, 30'd0);
        send_beat(OP_INIT, 12'd0);
        random_beats(30);

        // Long receiver hold-off while reads stream in back to back.
        load_regs(VAL_W'($urandom_range(999999999)), rand_thr(), rand_thr());
        quiet_sender = 1'b1;
        hold_asks    = hold_asks + 1;
        for (int n = 0; n < 20; n++)
            send_beat(OP_READ, SITE_W'($urandom));
        quiet_sender = 1'b0;
        random_beats(15);

        load_regs(VAL_W'($urandom_range(999999999)), rand_thr(), rand_thr());
        send_beat(OP_INIT, 12'd0);
        random_beats(35);

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (lattice_sb.errors == 0 && lattice_sb.owed.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ims_pkg.sv
rtl/ims_if.sv
rtl/ising_metropolis_sweep_engine.sv
rtl/ims_check.sv
tb/ising_metropolis_sweep_engine_tb.sv
